>>> src/tcw_pkg.sv
`default_nettype none
package tcw_pkg;

   localparam int ROW_W  = 32;
   localparam int IDX_W  = 5;
   localparam int CSR_W  = 6;

   typedef struct packed {
      logic [ROW_W-1:0] row_bits;
      logic [ROW_W-1:0] unknown_bits;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0] closed_row;
      logic [IDX_W-1:0] row_index;
      logic             error;
      logic             last_row;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_CLOSE,
      ST_EMIT
   } state_type;

   // lane controls, shared by every row lane
   typedef struct packed {
      logic load;
      logic close;
      logic shift;
   } lane_ctl_type;

   // emit controls towards the merging stage
   typedef struct packed {
      logic             emit;
      logic [IDX_W-1:0] index;
      logic             error;
      logic             last_row;
   } emit_type;

endpackage
`default_nettype wire

>>> src/tcw_lane.sv
`default_nettype none
module tcw_lane (
   input  logic                    clock,
   input  tcw_pkg::lane_ctl_type   ctl,
   input  logic                    wr_hit,
   input  logic [tcw_pkg::ROW_W-1:0] wr_row,
   input  logic [tcw_pkg::IDX_W-1:0] pivot_idx,
   input  logic [tcw_pkg::ROW_W-1:0] pivot_row,
   input  logic [tcw_pkg::ROW_W-1:0] next_row,
   output logic [tcw_pkg::ROW_W-1:0] row
);
   import tcw_pkg::*;

   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;

   always_comb begin
      row_in = row_ff;
      if (ctl.load && wr_hit) begin
         row_in = wr_row;
      end else if (ctl.close) begin
         // pull in the pivot row when this row reaches the pivot
         if (row_ff[pivot_idx]) begin
            row_in = row_ff | pivot_row;
         end
      end else if (ctl.shift) begin
         row_in = next_row;
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
   end

   assign row = row_ff;

endmodule
`default_nettype wire

>>> src/tcw_merge.sv
`default_nettype none
module tcw_merge #(
   parameter int DEPTH = 32,
   parameter int SEL_W = 5
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [DEPTH-1:0][tcw_pkg::ROW_W-1:0] lane_rows,
   input  logic [SEL_W-1:0]                    pivot_sel,
   input  tcw_pkg::emit_type                   emit,
   output logic [tcw_pkg::ROW_W-1:0]           pivot_row,
   output logic                                rsp_valid,
   output tcw_pkg::rsp_type                    rsp_item
);
   import tcw_pkg::*;

   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_item_ff;
   rsp_type rsp_item_in;

   assign pivot_row = lane_rows[pivot_sel];

   always_comb begin
      rsp_valid_in            = emit.emit;
      rsp_item_in.closed_row  = emit.error ? '0 : lane_rows[0];
      rsp_item_in.row_index   = emit.index;
      rsp_item_in.error       = emit.error;
      rsp_item_in.last_row    = emit.last_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.emit) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef SYNTHESIS
   a_err_zero_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.error |-> rsp_item.closed_row == '0)
      else $error("error row carries data");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.last_row |=> !rsp_valid)
      else $error("result strobe straight after last row");
`endif

endmodule
`default_nettype wire

>>> src/tcw_ctrl.sv
`default_nettype none
module tcw_ctrl #(
   parameter int DEPTH = 32,
   parameter int SEL_W = 5
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [tcw_pkg::CSR_W-1:0]    csr_wdata,
   input  logic [tcw_pkg::ROW_W-1:0]    unknown_bits,
   output logic [tcw_pkg::ROW_W-1:0]    col_mask,
   output tcw_pkg::lane_ctl_type        lane_ctl,
   output logic [SEL_W-1:0]             load_sel,
   output logic [SEL_W-1:0]             step,
   output tcw_pkg::emit_type            emit
);
   import tcw_pkg::*;

   localparam int LIM = (DEPTH < 32) ? DEPTH : 32;
   localparam logic [ROW_W-1:0] RST_MASK =
      (LIM >= 32) ? {ROW_W{1'b1}} : ROW_W'((64'd1 << LIM) - 64'd1);

   state_type        state_ff, state_in;
   logic [SEL_W-1:0] cnt_ff, cnt_in;
   logic [SEL_W-1:0] step_ff, step_in;
   logic [SEL_W-1:0] last_ff, last_in;
   logic [ROW_W-1:0] mask_ff, mask_in;
   logic             unk_ff, unk_in;
   logic [CSR_W-1:0] size_clamp;
   logic             accept;
   logic             csr_wr;

   always_comb begin
      // saturate the written size to 1..LIM
      if (csr_wdata == '0) begin
         size_clamp = CSR_W'(1);
      end else if (csr_wdata > CSR_W'(LIM)) begin
         size_clamp = CSR_W'(LIM);
      end else begin
         size_clamp = csr_wdata;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      step_in      = step_ff;
      last_in      = last_ff;
      mask_in      = mask_ff;
      unk_in       = unk_ff;
      busy         = 1'b1;
      csr_ready    = 1'b0;
      accept       = 1'b0;
      csr_wr       = 1'b0;
      lane_ctl     = '0;
      emit         = '0;
      emit.index   = IDX_W'(step_ff);
      emit.error   = unk_ff;
      emit.last_row = (step_ff == last_ff);

      case (state_ff)
         ST_LOAD: begin
            busy      = 1'b0;
            // take a pending item first and hold the size write off
            csr_ready = !start;
            accept    = start;
            csr_wr    = csr_valid && !start;
            if (csr_wr) begin
               // new size drops any partial load
               last_in = SEL_W'(size_clamp - CSR_W'(1));
               mask_in = size_clamp[CSR_W-1] ? {ROW_W{1'b1}}
                                             : (ROW_W'(1) << size_clamp[IDX_W-1:0]) - ROW_W'(1);
               cnt_in  = '0;
               unk_in  = 1'b0;
            end else if (accept) begin
               lane_ctl.load = 1'b1;
               if ((unknown_bits & mask_ff) != '0) begin
                  unk_in = 1'b1;
               end
               if (cnt_ff == last_ff) begin
                  cnt_in   = '0;
                  step_in  = '0;
                  state_in = ST_CLOSE;
               end else begin
                  cnt_in = cnt_ff + SEL_W'(1);
               end
            end
         end
         ST_CLOSE: begin
            lane_ctl.close = 1'b1;
            if (step_ff == last_ff) begin
               step_in  = '0;
               state_in = ST_EMIT;
            end else begin
               step_in = step_ff + SEL_W'(1);
            end
         end
         ST_EMIT: begin
            lane_ctl.shift = 1'b1;
            emit.emit      = 1'b1;
            if (step_ff == last_ff) begin
               step_in  = '0;
               unk_in   = 1'b0;
               state_in = ST_LOAD;
            end else begin
               step_in = step_ff + SEL_W'(1);
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
         step_ff  <= '0;
         last_ff  <= SEL_W'(LIM - 1);
         mask_ff  <= RST_MASK;
         unk_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         step_ff  <= step_in;
         last_ff  <= last_in;
         mask_ff  <= mask_in;
         unk_ff   <= unk_in;
      end
   end

   assign col_mask = mask_ff;
   assign load_sel = cnt_ff;
   assign step     = step_ff;

`ifndef SYNTHESIS
   a_load_to_close: assert property (@(posedge clock) disable iff (reset)
      accept && !csr_wr && cnt_ff == last_ff |=> state_ff == ST_CLOSE && step_ff == '0)
      else $error("full matrix did not start closure");

   a_emit_to_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && step_ff == last_ff |=> state_ff == ST_LOAD && !unk_ff
         && cnt_ff == '0)
      else $error("run did not return to load cleanly");

   a_csr_clears: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> cnt_ff == '0 && !unk_ff)
      else $error("size write left a partial load");
`endif

endmodule
`default_nettype wire

>>> src/transitive_closure_warshall_unit.sv
`default_nettype none
// Warshall closure of a square boolean relation of active_size rows (n).
// Rows load one per start while busy is low; once row n-1 is in, busy
// rises and every row lane folds in pivot row k in parallel, one pivot per
// cycle for k = 0 to n-1; then the closed rows leave as a burst of n
// rsp_valid strobes on consecutive cycles, row 0 first, last_row on the
// final one. The receiver cannot stall: each item is valid on rsp_item for
// exactly one cycle. A new matrix cannot load until the last is emitted.
// A size write (taken while busy is low and start is low) abandons any
// partial load.
module transitive_closure_warshall_unit #(
   parameter int MAX_SIZE = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  tcw_pkg::req_type          req_item,
   output logic                      rsp_valid,
   output tcw_pkg::rsp_type          rsp_item,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [tcw_pkg::CSR_W-1:0] csr_wdata
);
   import tcw_pkg::*;

   localparam int DEPTH = (MAX_SIZE < 32) ? MAX_SIZE : 32;
   localparam int SEL_W = $clog2(DEPTH);

   logic [DEPTH-1:0][ROW_W-1:0] lane_rows;
   logic [ROW_W-1:0]            col_mask;
   logic [ROW_W-1:0]            wr_row;
   logic [ROW_W-1:0]            pivot_row;
   logic [SEL_W-1:0]            load_sel;
   logic [SEL_W-1:0]            step;
   lane_ctl_type                lane_ctl;
   emit_type                    emit;

   tcw_ctrl #(
      .DEPTH (DEPTH),
      .SEL_W (SEL_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_wdata    (csr_wdata),
      .unknown_bits (req_item.unknown_bits),
      .col_mask     (col_mask),
      .lane_ctl     (lane_ctl),
      .load_sel     (load_sel),
      .step         (step),
      .emit         (emit)
   );

   // drop columns beyond the active size on the way in
   assign wr_row = req_item.row_bits & col_mask;

   for (genvar i = 0; i < DEPTH; i++) begin : g_lane
      logic [ROW_W-1:0] next_row;

      if (i == DEPTH - 1) begin : g_tail
         assign next_row = lane_rows[i];
      end else begin : g_body
         assign next_row = lane_rows[i+1];
      end

      tcw_lane u_lane (
         .clock     (clock),
         .ctl       (lane_ctl),
         .wr_hit    (load_sel == SEL_W'(i)),
         .wr_row    (wr_row),
         .pivot_idx (IDX_W'(step)),
         .pivot_row (pivot_row),
         .next_row  (next_row),
         .row       (lane_rows[i])
      );
   end

   tcw_merge #(
      .DEPTH (DEPTH),
      .SEL_W (SEL_W)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .lane_rows (lane_rows),
      .pivot_sel (step),
      .emit      (emit),
      .pivot_row (pivot_row),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule
`default_nettype wire
